FILE: src/pesc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the projection function for the polygon edge
// crossing core. No dependencies.
package pesc_pkg;

    localparam int COORD_W          = 32;
    localparam int POINT_W          = 2 * COORD_W;
    localparam int SIDE_W           = 10;
    localparam int LIM_W            = 16;
    localparam int AXIS_W           = 2;
    localparam int CFG_AW           = 5;
    localparam int CFG_DW           = 32;
    localparam int DEF_MAX_VERTICES = 1024;

    // datapath widths of the edge test unit
    localparam int DIFF_W = COORD_W + 1;   // coordinate difference
    localparam int WIDE_W = 68;            // cross products, squared lengths
    localparam int ENG_W  = 168;           // accumulator, holds the threshold products
    localparam int DVD_W  = 100;           // |component * cross| dividend
    localparam int CNT_W  = 7;

    localparam logic [CNT_W-1:0] LAST_DIFF = CNT_W'(DIFF_W - 1);
    localparam logic [CNT_W-1:0] LAST_WIDE = CNT_W'(WIDE_W - 1);
    localparam logic [CNT_W-1:0] LAST_LIM  = CNT_W'(LIM_W);
    localparam logic [CNT_W-1:0] LAST_DVD  = CNT_W'(DVD_W - 1);

    // register map (word index)
    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_START_Z = 3'd2;
    localparam logic [2:0] REG_END_X   = 3'd3;
    localparam logic [2:0] REG_END_Y   = 3'd4;
    localparam logic [2:0] REG_END_Z   = 3'd5;
    localparam logic [2:0] REG_AXIS    = 3'd6;
    localparam logic [2:0] REG_LIMIT   = 3'd7;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    localparam logic [AXIS_W-1:0] RST_AXIS  = AXIS_Z;
    localparam logic [LIM_W-1:0]  RST_LIMIT = 16'd66;

    typedef enum logic [1:0] {
        T_IDLE,
        T_RUN,
        T_PUT
    } t_top_state;

    typedef enum logic [3:0] {
        E_IDLE,
        E_LOAD,
        E_MAC,
        E_STORE,
        E_NEG,
        E_CHK,
        E_ABS,
        E_DIV,
        E_FIN,
        E_DONE
    } t_eng_state;

    typedef enum logic [3:0] {
        OP_RXS1,
        OP_RXS2,
        OP_RR1,
        OP_RR2,
        OP_SS1,
        OP_SS2,
        OP_LHS,
        OP_RRSS,
        OP_RHS1,
        OP_RHS2,
        OP_QXS1,
        OP_QXS2,
        OP_QXR1,
        OP_QXR2,
        OP_PU,
        OP_PV
    } t_op;

    typedef struct packed {
        logic [COORD_W-1:0] p0u;
        logic [COORD_W-1:0] p0v;
        logic [COORD_W-1:0] p1u;
        logic [COORD_W-1:0] p1v;
        logic [COORD_W-1:0] q0u;
        logic [COORD_W-1:0] q0v;
        logic [COORD_W-1:0] q1u;
        logic [COORD_W-1:0] q1v;
    } t_edge_req;

    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
    } t_edge_res;

    // returns {v, u}; the unused axis code drops z
    function automatic logic [POINT_W-1:0] f_project(input logic [AXIS_W-1:0] axis,
                                                    input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
        logic [POINT_W-1:0] p;
        case (axis)
            AXIS_X:  p = {z, y};
            AXIS_Y:  p = {z, x};
            default: p = {y, x};
        endcase
        return p;
    endfunction

endpackage

FILE: src/polygon_edge_segment_crossing_core.sv
`timescale 1ns / 1ps
// Polygon edge against query edge crossing core: register port, vertex
// tracking and output register around pesc_engine. Depends on pesc_pkg and pesc_engine.
//
// Each polygon edge is tested by one shared add/subtract unit stepping a
// shift-add multiplier and a bit-serial divider; a missed edge ends before
// the two divisions that a hit runs. A vertex that closes the polygon after
// an earlier vertex carries its edge from the previous vertex and the edge
// back to the first. The input is not ready during an edge test; the result
// register lets the next vertex in while a result still waits to be taken.
module polygon_edge_segment_crossing_core #(
    parameter int MAX_VERTICES = pesc_pkg::DEF_MAX_VERTICES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // vert_x, vert_y, vert_z
    input  logic        s_axis_tlast,   // final_vertex
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // point_u, point_v, side_index, zero pad
    output logic        m_axis_tuser,   // hit
    output logic        m_axis_tlast    // run_end
);
    import pesc_pkg::*;

    localparam int CW = $clog2(MAX_VERTICES);
    localparam int IW = (CW > SIDE_W) ? CW : SIDE_W;

    logic [COORD_W-1:0] r_sx, r_sy, r_sz, r_ex, r_ey, r_ez;
    logic [AXIS_W-1:0]  r_axis;
    logic [LIM_W-1:0]   r_lim;

    logic [POINT_W-1:0] r_first, r_prev;
    logic [CW-1:0]      r_count, r_job_idx, r_pidx;
    logic               r_job_last, r_pend;
    t_top_state         r_state, n_state;

    logic               r_ovalid, r_olast, r_ohit;
    logic [COORD_W-1:0] r_ou, r_ov;
    logic [SIDE_W-1:0]  r_oside;

    logic               in_xfer, cfg_wr, can_load, eng_start, eng_done;
    logic [POINT_W-1:0] cur_p, q0, q1;
    logic [CW:0]        cnt_inc;
    logic [CW-1:0]      cnt_next;
    logic [IW-1:0]      idx_ext;
    t_edge_req          req;
    t_edge_res          res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == T_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0; r_sy <= '0; r_sz <= '0;
            r_ex <= '0; r_ey <= '0; r_ez <= '0;
            r_axis <= RST_AXIS;
            r_lim  <= RST_LIMIT;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_START_X: r_sx <= pwdata;
                REG_START_Y: r_sy <= pwdata;
                REG_START_Z: r_sz <= pwdata;
                REG_END_X:   r_ex <= pwdata;
                REG_END_Y:   r_ey <= pwdata;
                REG_END_Z:   r_ez <= pwdata;
                REG_AXIS:    r_axis <= pwdata[AXIS_W-1:0];
                REG_LIMIT:   r_lim  <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_START_X: prdata = r_sx;
            REG_START_Y: prdata = r_sy;
            REG_START_Z: prdata = r_sz;
            REG_END_X:   prdata = r_ex;
            REG_END_Y:   prdata = r_ey;
            REG_END_Z:   prdata = r_ez;
            REG_AXIS:    prdata = CFG_DW'(r_axis);
            REG_LIMIT:   prdata = CFG_DW'(r_lim);
            default:     prdata = '0;
        endcase
    end

    assign cur_p = f_project(r_axis, s_axis_tdata[31:0], s_axis_tdata[63:32],
                             s_axis_tdata[95:64]);
    assign q0    = f_project(r_axis, r_sx, r_sy, r_sz);
    assign q1    = f_project(r_axis, r_ex, r_ey, r_ez);

    assign cnt_inc  = {1'b0, r_count} + 1'b1;
    assign cnt_next = (cnt_inc < (CW+1)'(MAX_VERTICES)) ? cnt_inc[CW-1:0]
                                                        : CW'(MAX_VERTICES - 1);

    assign can_load = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state   = r_state;
        eng_start = 1'b0;
        req.q0u = q0[COORD_W-1:0];
        req.q0v = q0[POINT_W-1:COORD_W];
        req.q1u = q1[COORD_W-1:0];
        req.q1v = q1[POINT_W-1:COORD_W];
        // closing edge back to first: prev already holds the closing vertex
        req.p0u = r_prev[COORD_W-1:0];
        req.p0v = r_prev[POINT_W-1:COORD_W];
        req.p1u = r_first[COORD_W-1:0];
        req.p1v = r_first[POINT_W-1:COORD_W];
        case (r_state)
            T_IDLE: begin
                if (r_count != '0) begin
                    req.p0u = r_prev[COORD_W-1:0];
                    req.p0v = r_prev[POINT_W-1:COORD_W];
                end else begin
                    req.p0u = cur_p[COORD_W-1:0];
                    req.p0v = cur_p[POINT_W-1:COORD_W];
                end
                req.p1u = cur_p[COORD_W-1:0];
                req.p1v = cur_p[POINT_W-1:COORD_W];
                if (in_xfer && ((r_count != '0) || s_axis_tlast)) begin
                    eng_start = 1'b1;
                    n_state   = T_RUN;
                end
            end
            T_RUN: begin
                if (eng_done) n_state = T_PUT;
            end
            T_PUT: begin
                if (can_load) begin
                    if (r_pend) begin
                        eng_start = 1'b1;
                        n_state   = T_RUN;
                    end else begin
                        n_state   = T_IDLE;
                    end
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_count  <= '0;
            r_first  <= '0;
            r_prev   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                if (r_count == '0) r_first <= cur_p;
                r_prev <= cur_p;
                r_count <= s_axis_tlast ? '0 : cnt_next;
                r_pidx  <= r_count;
                if (r_count != '0) begin
                    r_job_idx  <= r_count - 1'b1;
                    r_job_last <= 1'b0;
                    r_pend     <= s_axis_tlast;
                end else begin
                    r_job_idx  <= '0;
                    r_job_last <= 1'b1;
                    r_pend     <= 1'b0;
                end
            end
            if ((r_state == T_PUT) && can_load) begin
                r_ovalid <= 1'b1;
                r_ohit   <= res.hit;
                r_ou     <= res.u;
                r_ov     <= res.v;
                r_oside  <= idx_ext[SIDE_W-1:0];
                r_olast  <= r_job_last;
                if (r_pend) begin
                    r_job_idx  <= r_pidx;
                    r_job_last <= 1'b1;
                    r_pend     <= 1'b0;
                end
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign idx_ext = IW'(r_job_idx);

    pesc_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (eng_start),
        .i_req   (req),
        .i_lim   (r_lim),
        .o_done  (eng_done),
        .o_res   (res)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ohit;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {6'd0, r_oside, r_ov, r_ou};

endmodule

FILE: src/pesc_engine.sv
`timescale 1ns / 1ps
// Edge test unit: one shared add/subtract drives a shift-add multiplier and a
// restoring divider under a small sequencer. Depends on pesc_pkg.
module pesc_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pesc_pkg::t_edge_req  i_req,
    input  logic [15:0]          i_lim,
    output logic                 o_done,
    output pesc_pkg::t_edge_res  o_res
);
    import pesc_pkg::*;

    t_eng_state r_state, n_state;
    t_op        r_op, n_op;

    logic [DIFF_W-1:0] r_rx, r_ry, r_sx, r_sy, r_qx, r_qy;
    logic [COORD_W-1:0] r_bu, r_bv;
    logic [WIDE_W-1:0] r_rxs, r_rr, r_ss, r_qxs, r_qxr, r_mplier, r_rem;
    logic [ENG_W-1:0]  r_acc, r_mcand, r_lhs, r_big;
    logic [DVD_W-1:0]  r_dvd;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_sub, r_rneg, r_qneg, r_chk;
    logic [LIM_W-1:0]  r_lim;
    t_edge_res         r_res;

    logic [ENG_W-1:0]  add_a, add_b, add_y;
    logic              add_sub;
    logic [ENG_W-1:0]  ld_a;
    logic [WIDE_W-1:0] ld_b;
    logic [CNT_W-1:0]  ld_cnt;
    logic              ld_keep, ld_sub;
    logic [WIDE_W-1:0] chk_val;
    logic              chk_ok;

    function automatic logic [ENG_W-1:0] f_wd(input logic [DIFF_W-1:0] x);
        return {{(ENG_W-DIFF_W){x[DIFF_W-1]}}, x};
    endfunction

    function automatic logic [ENG_W-1:0] f_ww(input logic [WIDE_W-1:0] x);
        return {{(ENG_W-WIDE_W){x[WIDE_W-1]}}, x};
    endfunction

    function automatic logic [WIDE_W-1:0] f_bd(input logic [DIFF_W-1:0] x);
        return {{(WIDE_W-DIFF_W){x[DIFF_W-1]}}, x};
    endfunction

    function automatic logic [ENG_W-1:0] f_wc(input logic [COORD_W-1:0] x);
        return {{(ENG_W-COORD_W){x[COORD_W-1]}}, x};
    endfunction

    function automatic logic [DIFF_W-1:0] f_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    // the one shared adder
    assign add_y = add_a + (add_sub ? ~add_b : add_b) + ENG_W'(add_sub);

    assign chk_val = r_chk ? r_qxr : r_qxs;
    // strict 0 < val < rxs, rxs already made positive
    assign chk_ok  = !chk_val[WIDE_W-1] && (chk_val != '0) && add_y[ENG_W-1];

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            E_MAC: begin
                add_a   = r_acc;
                add_b   = r_mcand;
                // top multiplier bit carries negative weight
                add_sub = r_sub ^ (r_cnt == '0);
            end
            E_NEG, E_ABS: begin
                add_b   = r_acc;
                add_sub = 1'b1;
            end
            E_CHK: begin
                add_a   = f_ww(chk_val);
                add_b   = f_ww(r_rxs);
                add_sub = 1'b1;
            end
            E_DIV: begin
                add_a   = ENG_W'({r_rem[WIDE_W-2:0], r_dvd[DVD_W-1]});
                add_b   = f_ww(r_rxs);
                add_sub = 1'b1;
            end
            E_FIN: begin
                add_a   = f_wc((r_op == OP_PU) ? r_bu : r_bv);
                add_b   = ENG_W'(r_dvd);
                add_sub = r_qneg;
            end
            default: ;
        endcase
    end

    // operand selection for each multiply step
    always_comb begin
        ld_a    = '0;
        ld_b    = '0;
        ld_cnt  = LAST_DIFF;
        ld_keep = 1'b0;
        ld_sub  = 1'b0;
        case (r_op)
            OP_RXS1: begin ld_a = f_wd(r_rx); ld_b = f_bd(r_sy); end
            OP_RXS2: begin
                ld_a = f_wd(r_ry); ld_b = f_bd(r_sx); ld_keep = 1'b1; ld_sub = 1'b1;
            end
            OP_RR1:  begin ld_a = f_wd(r_rx); ld_b = f_bd(r_rx); end
            OP_RR2:  begin ld_a = f_wd(r_ry); ld_b = f_bd(r_ry); ld_keep = 1'b1; end
            OP_SS1:  begin ld_a = f_wd(r_sx); ld_b = f_bd(r_sx); end
            OP_SS2:  begin ld_a = f_wd(r_sy); ld_b = f_bd(r_sy); ld_keep = 1'b1; end
            OP_LHS: begin
                ld_a = f_ww(r_rxs) << COORD_W; ld_b = r_rxs; ld_cnt = LAST_WIDE;
            end
            OP_RRSS: begin ld_a = f_ww(r_rr); ld_b = r_ss; ld_cnt = LAST_WIDE; end
            OP_RHS1: begin ld_a = r_big; ld_b = WIDE_W'(r_lim); ld_cnt = LAST_LIM; end
            OP_RHS2: begin
                // acc starts at lhs, so the result sign is the threshold compare
                ld_a = r_big; ld_b = WIDE_W'(r_lim); ld_cnt = LAST_LIM;
                ld_keep = 1'b1; ld_sub = 1'b1;
            end
            OP_QXS1: begin ld_a = f_wd(r_qx); ld_b = f_bd(r_sy); ld_sub = r_rneg; end
            OP_QXS2: begin
                ld_a = f_wd(r_qy); ld_b = f_bd(r_sx); ld_keep = 1'b1; ld_sub = !r_rneg;
            end
            OP_QXR1: begin ld_a = f_wd(r_qx); ld_b = f_bd(r_ry); ld_sub = r_rneg; end
            OP_QXR2: begin
                ld_a = f_wd(r_qy); ld_b = f_bd(r_rx); ld_keep = 1'b1; ld_sub = !r_rneg;
            end
            OP_PU:   begin ld_a = f_wd(r_rx); ld_b = r_qxs; ld_cnt = LAST_WIDE; end
            OP_PV:   begin ld_a = f_wd(r_ry); ld_b = r_qxs; ld_cnt = LAST_WIDE; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_op    <= OP_RXS1;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_done  = 1'b0;
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_state = E_LOAD;
                    n_op    = OP_RXS1;
                end
            end
            E_LOAD: n_state = E_MAC;
            E_MAC: begin
                if (r_cnt == '0) n_state = E_STORE;
            end
            E_STORE: begin
                n_state = E_LOAD;
                case (r_op)
                    OP_RXS1: n_op = OP_RXS2;
                    OP_RXS2: begin
                        if (r_acc == '0)           n_state = E_DONE;
                        else if (r_acc[ENG_W-1])   n_state = E_NEG;
                        else                       n_op    = OP_RR1;
                    end
                    OP_RR1:  n_op = OP_RR2;
                    OP_RR2:  n_op = OP_SS1;
                    OP_SS1:  n_op = OP_SS2;
                    OP_SS2:  n_op = OP_LHS;
                    OP_LHS:  n_op = OP_RRSS;
                    OP_RRSS: n_op = OP_RHS1;
                    OP_RHS1: n_op = OP_RHS2;
                    OP_RHS2: begin
                        if (r_acc[ENG_W-1]) n_state = E_DONE;
                        else                n_op    = OP_QXS1;
                    end
                    OP_QXS1: n_op = OP_QXS2;
                    OP_QXS2: n_op = OP_QXR1;
                    OP_QXR1: n_op = OP_QXR2;
                    OP_QXR2: n_state = E_CHK;
                    default: n_state = E_ABS;
                endcase
            end
            E_NEG: begin
                n_state = E_LOAD;
                n_op    = OP_RR1;
            end
            E_CHK: begin
                if (!chk_ok) begin
                    n_state = E_DONE;
                end else if (r_chk) begin
                    n_state = E_LOAD;
                    n_op    = OP_PU;
                end
            end
            E_ABS: n_state = E_DIV;
            E_DIV: begin
                if (r_cnt == '0) n_state = E_FIN;
            end
            E_FIN: begin
                if (r_op == OP_PU) begin
                    n_state = E_LOAD;
                    n_op    = OP_PV;
                end else begin
                    n_state = E_DONE;
                end
            end
            E_DONE: begin
                o_done  = 1'b1;
                n_state = E_IDLE;
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    r_rx   <= f_diff(i_req.p1u, i_req.p0u);
                    r_ry   <= f_diff(i_req.p1v, i_req.p0v);
                    r_sx   <= f_diff(i_req.q1u, i_req.q0u);
                    r_sy   <= f_diff(i_req.q1v, i_req.q0v);
                    r_qx   <= f_diff(i_req.q0u, i_req.p0u);
                    r_qy   <= f_diff(i_req.q0v, i_req.p0v);
                    r_bu   <= i_req.p0u;
                    r_bv   <= i_req.p0v;
                    r_lim  <= i_lim;
                    r_res  <= '0;
                    r_rneg <= 1'b0;
                    r_chk  <= 1'b0;
                end
            end
            E_LOAD: begin
                r_mcand  <= ld_a;
                r_mplier <= ld_b;
                r_cnt    <= ld_cnt;
                r_sub    <= ld_sub;
                if (r_op == OP_RHS2) r_acc <= r_lhs;
                else if (!ld_keep)   r_acc <= '0;
            end
            E_MAC: begin
                if (r_mplier[0]) r_acc <= add_y;
                r_mcand  <= r_mcand << 1;
                r_mplier <= {r_mplier[WIDE_W-1], r_mplier[WIDE_W-1:1]};
                r_cnt    <= r_cnt - 1'b1;
            end
            E_STORE: begin
                case (r_op)
                    OP_RXS2: r_rxs <= r_acc[WIDE_W-1:0];
                    OP_RR2:  r_rr  <= r_acc[WIDE_W-1:0];
                    OP_SS2:  r_ss  <= r_acc[WIDE_W-1:0];
                    OP_LHS:  r_lhs <= r_acc;
                    OP_RRSS, OP_RHS1: r_big <= r_acc;
                    OP_QXS2: r_qxs <= r_acc[WIDE_W-1:0];
                    OP_QXR2: r_qxr <= r_acc[WIDE_W-1:0];
                    default: ;
                endcase
            end
            E_NEG: begin
                r_rxs  <= add_y[WIDE_W-1:0];
                r_rneg <= 1'b1;
            end
            E_CHK: r_chk <= 1'b1;
            E_ABS: begin
                r_qneg <= r_acc[ENG_W-1];
                r_dvd  <= r_acc[ENG_W-1] ? add_y[DVD_W-1:0] : r_acc[DVD_W-1:0];
                r_rem  <= '0;
                r_cnt  <= LAST_DVD;
            end
            E_DIV: begin
                // restoring step, quotient bits shift in behind the dividend
                if (add_y[ENG_W-1]) r_rem <= {r_rem[WIDE_W-2:0], r_dvd[DVD_W-1]};
                else                r_rem <= add_y[WIDE_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], !add_y[ENG_W-1]};
                r_cnt <= r_cnt - 1'b1;
            end
            E_FIN: begin
                if (r_op == OP_PU) begin
                    r_res.u <= add_y[COORD_W-1:0];
                end else begin
                    r_res.v   <= add_y[COORD_W-1:0];
                    r_res.hit <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_res = r_res;

endmodule

FILE: src/pesc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the crossing core, bound onto the top level.
// Depends only on the top level's ports.
module pesc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a miss carries a zero crossing point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:0] == 64'd0)
        else $error("miss with non-zero point");

    // a closing vertex always starts an edge test
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after closing vertex");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("register port stalled");

endmodule

bind polygon_edge_segment_crossing_core pesc_checker u_pesc_checker (.*);
